FILE: rtl/core/lge_pkg.sv
// Shared types, constants and the B3/S23 cell rule for the life generation engine.
// No dependencies; imported by lge_row_rule and the top level of the engine.
`default_nettype none

package lge_pkg;

  // Default grid capacity, handed to the top level parameters.
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Fixed field widths of the ports.
  localparam int OP_W      = 2;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Both size registers come out of reset at 64.
  localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } cfg_reg_t;

  // Next state of one cell from its live neighbor count and its old state.
  function automatic logic life_next(input logic [3:0] nbr_cnt, input logic alive);
    life_next = (nbr_cnt == 4'd3) | ((nbr_cnt == 4'd2) & alive);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lge_cell.sv
// One storage cell of the rotating row chain: holds one row word of the grid.
// Depends on nothing but its neighbor; the word moves one place every cycle.
`default_nettype none

module lge_cell #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [WIDTH-1:0] shift_in,
  output logic [WIDTH-1:0] word_out
);

  logic [WIDTH-1:0] word_r;

  // The grid resets to all dead cells.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= shift_in;
    end
  end

  assign word_out = word_r;

endmodule

`default_nettype wire

FILE: rtl/core/lge_row_rule.sv
// Computes the next generation of one row word from the old row and its two neighbors.
// Uses life_next from lge_pkg; rows outside the grid arrive as zero words.
`default_nettype none

module lge_row_rule
  import lge_pkg::*;
#(
  parameter int WIDTH = 64,
  parameter int CNT_W = 7
) (
  input  logic [WIDTH-1:0] above_i,
  input  logic [WIDTH-1:0] cur_i,
  input  logic [WIDTH-1:0] below_i,
  input  logic [CNT_W-1:0] used_cols_i,
  output logic [WIDTH-1:0] next_o
);

  logic [WIDTH-1:0] col_mask;
  logic [WIDTH+1:0] a_pad;
  logic [WIDTH+1:0] c_pad;
  logic [WIDTH+1:0] b_pad;
  logic [3:0]       nbr_cnt [WIDTH];

  always_comb begin
    for (int c = 0; c < WIDTH; c++) begin
      col_mask[c] = (CNT_W'(c) < used_cols_i);
    end
  end

  // Columns past the grid and the borders count as dead.
  assign a_pad = {1'b0, above_i & col_mask, 1'b0};
  assign c_pad = {1'b0, cur_i & col_mask, 1'b0};
  assign b_pad = {1'b0, below_i & col_mask, 1'b0};

  always_comb begin
    for (int c = 0; c < WIDTH; c++) begin
      nbr_cnt[c] = 4'(a_pad[c]) + 4'(a_pad[c+1]) + 4'(a_pad[c+2])
                 + 4'(c_pad[c]) + 4'(c_pad[c+2])
                 + 4'(b_pad[c]) + 4'(b_pad[c+1]) + 4'(b_pad[c+2]);
      next_o[c]  = col_mask[c] ? life_next(nbr_cnt[c], cur_i[c]) : cur_i[c];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/life_generation_engine_top.sv
// Top level of the life generation engine: a rotating chain of row cells plus its sequencer.
// Depends on lge_pkg, lge_cell and lge_row_rule.
//
// Usage: the engine holds a MAX_ROWS by MAX_COLS bit grid of live cells. Each input
// word on the in_ channel (valid/ready) writes one cell, reads one cell, advances the
// grid by one B3/S23 generation on a bounded grid, or (unused opcode) does nothing.
// Every input word yields exactly one result word on the out_ channel (valid/ready).
// The cfg_ channel writes the row count (index 0) or column count (index 1); it is
// always ready and must only be used while the engine is idle.
// The grid rows circulate through a chain of MAX_ROWS cells, one place per cycle, so
// the row at the head of the chain changes every cycle. A read or write waits until its
// row reaches the head, then the result register is loaded. An advance waits for row 0
// at the head, then updates one row per cycle as the rows pass. Accesses outside the
// grid and the unused opcode skip the row search and go straight to the result. One
// word is in work at a time; the next word is accepted as soon as the engine is idle,
// even while the previous result still waits on a stalled receiver. A stalled receiver
// holds the next result back but never loses it. Reset clears the whole grid and sets
// both sizes to 64.
`default_nettype none

module life_generation_engine_top
  import lge_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input channel.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [ROW_W-1:0]     in_row,
  input  logic [COL_W-1:0]     in_col,
  input  logic                 in_alive_in,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_alive_out,
  output logic [OP_W-1:0]      out_op_done,
  output logic                 out_out_of_range,
  // Configuration channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int RowIdxW = $clog2(MAX_ROWS);
  localparam int ColIdxW = $clog2(MAX_COLS);
  localparam int CntW    = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SEEK = 4'b0010,
    ST_GEN  = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  // Configuration registers.
  logic [CFG_W-1:0] grid_rows_r;
  logic [CFG_W-1:0] grid_cols_r;
  logic [CntW-1:0]  rows_ext;
  logic [CntW-1:0]  cols_ext;
  logic [CntW-1:0]  used_rows;
  logic [CntW-1:0]  used_cols;
  logic [CntW-1:0]  last_row;

  // Sequencer and captured request.
  state_t             state_r, state_nxt;
  logic [RowIdxW-1:0] head_r, head_nxt;
  logic [CntW-1:0]    head_ext;
  opcode_t            req_op_r;
  logic [ROW_W-1:0]   req_row_r;
  logic [COL_W-1:0]   req_col_r;
  logic               req_val_r;
  logic               req_oor_r;
  logic               res_alive_r;
  logic               in_oor;
  logic               in_accept;

  // Result register.
  logic            out_valid_r, out_valid_nxt;
  logic            out_alive_r;
  logic [OP_W-1:0] out_op_r;
  logic            out_oor_r;
  logic            out_free;
  logic            out_load;

  // Row chain and datapath.
  logic [MAX_COLS-1:0] chain_word [MAX_ROWS];
  logic [MAX_COLS-1:0] tail_in;
  logic [MAX_COLS-1:0] above_r;
  logic [MAX_COLS-1:0] above_w;
  logic [MAX_COLS-1:0] below_w;
  logic [MAX_COLS-1:0] gen_word;
  logic [MAX_COLS-1:0] wr_word;
  logic [MAX_COLS-1:0] col_sel;
  logic [ColIdxW-1:0]  col_idx;
  logic                rd_bit;
  logic                seek_hit;
  logic                access_hit;
  logic                gen_start;
  logic                gen_active;
  logic                gen_last;

  // ---------------------------------------------------------------------------
  // Configuration: sizes out of range are clamped to 1..MAX.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= GRID_SIZE_RESET;
      grid_cols_r <= GRID_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_ROWS: grid_rows_r <= cfg_data;
        REG_GRID_COLS: grid_cols_r <= cfg_data;
      endcase
    end
  end

  assign rows_ext = CntW'(grid_rows_r);
  assign cols_ext = CntW'(grid_cols_r);

  always_comb begin
    if (rows_ext == '0) begin
      used_rows = CntW'(1);
    end else if (rows_ext > CntW'(MAX_ROWS)) begin
      used_rows = CntW'(MAX_ROWS);
    end else begin
      used_rows = rows_ext;
    end
    if (cols_ext == '0) begin
      used_cols = CntW'(1);
    end else if (cols_ext > CntW'(MAX_COLS)) begin
      used_cols = CntW'(MAX_COLS);
    end else begin
      used_cols = cols_ext;
    end
  end

  assign last_row = used_rows - CntW'(1);

  // ---------------------------------------------------------------------------
  // Row chain: cell 0 is the head, the tail takes the (possibly updated) head word.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_chain
    if (i == MAX_ROWS - 1) begin : g_tail
      lge_cell #(.WIDTH(MAX_COLS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_in (tail_in),
        .word_out (chain_word[i])
      );
    end else begin : g_body
      lge_cell #(.WIDTH(MAX_COLS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_in (chain_word[i+1]),
        .word_out (chain_word[i])
      );
    end
  end

  // Row index of the word currently in the head cell.
  assign head_nxt = (head_r == RowIdxW'(MAX_ROWS - 1)) ? '0 : head_r + RowIdxW'(1);
  assign head_ext = CntW'(head_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  // The old value of the row just above the head; it has already left the head.
  always_ff @(posedge clk) begin
    above_r <= chain_word[0];
  end

  // Rows beyond the top and bottom borders are dead.
  assign above_w = (head_ext == '0) ? '0 : above_r;
  assign below_w = (head_ext == last_row) ? '0 : chain_word[1];

  lge_row_rule #(
    .WIDTH (MAX_COLS),
    .CNT_W (CntW)
  ) u_rule (
    .above_i     (above_w),
    .cur_i       (chain_word[0]),
    .below_i     (below_w),
    .used_cols_i (used_cols),
    .next_o      (gen_word)
  );

  // Single cell access on the head word.
  assign col_idx = req_col_r[ColIdxW-1:0];

  always_comb begin
    rd_bit = 1'b0;
    for (int c = 0; c < MAX_COLS; c++) begin
      col_sel[c] = (ColIdxW'(c) == col_idx);
      wr_word[c] = col_sel[c] ? req_val_r : chain_word[0][c];
      rd_bit     = rd_bit | (col_sel[c] & chain_word[0][c]);
    end
  end

  assign seek_hit   = (state_r == ST_SEEK);
  assign access_hit = seek_hit && (req_op_r != OP_ADVANCE)
                      && (head_ext == CntW'(req_row_r));
  assign gen_start  = seek_hit && (req_op_r == OP_ADVANCE) && (head_ext == '0);
  assign gen_active = gen_start || (state_r == ST_GEN);
  assign gen_last   = gen_active && (head_ext == last_row);

  always_comb begin
    if (gen_active) begin
      tail_in = gen_word;
    end else if (access_hit && (req_op_r == OP_WRITE)) begin
      tail_in = wr_word;
    end else begin
      tail_in = chain_word[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign in_oor    = ((in_opcode == OP_WRITE) || (in_opcode == OP_READ))
                     && ((CntW'(in_row) >= used_rows) || (CntW'(in_col) >= used_cols));
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = (state_r == ST_RESP) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_oor || (in_opcode == OP_NOP)) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_SEEK;
          end
        end
      end
      ST_SEEK: begin
        if (access_hit || gen_last) begin
          state_nxt = ST_RESP;
        end else if (gen_start) begin
          state_nxt = ST_GEN;
        end
      end
      ST_GEN: begin
        if (gen_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_op_r    <= opcode_t'(in_opcode);
      req_row_r   <= in_row;
      req_col_r   <= in_col;
      req_val_r   <= in_alive_in;
      req_oor_r   <= in_oor;
      res_alive_r <= 1'b0;
    end else if (access_hit && (req_op_r == OP_READ)) begin
      res_alive_r <= rd_bit;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_alive_r <= res_alive_r;
      out_op_r    <= req_op_r;
      out_oor_r   <= req_oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_alive_out    = out_alive_r;
  assign out_op_done      = out_op_r;
  assign out_out_of_range = out_oor_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_state_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_gen_in_grid : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN) |-> (head_ext != '0) && (head_ext < used_rows))
    else $error("generation update outside the rows in use");

  a_oor_skips_seek : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_oor) |=> (state_r == ST_RESP))
    else $error("out-of-range access did not skip the row search");

  a_access_done : assert property (@(posedge clk) disable iff (!rst_n)
    access_hit |=> (state_r == ST_RESP) && !$stable(head_r))
    else $error("cell access did not complete at its row");

  a_advance_result : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_op_r == OP_ADVANCE)) |-> !out_alive_r && !out_oor_r)
    else $error("advance result carries a cell value or range flag");

endmodule

`default_nettype wire
